FILE: src/okl_pkg.sv
// ----------------------------------------------------------------------------
// okl_pkg - shared types and constants for the ordered key list engine
// Command codes, controller states and the fixed field widths of the
// request and result channels.
// ----------------------------------------------------------------------------
package okl_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned IN_KEY_W   = 32;
  localparam int unsigned POSITION_W = 6;
  localparam int unsigned COUNT_W    = 7;

  // Request command codes; codes above clear do nothing
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_DEL_FIRST = 3'd1,
    CMD_DEL_ALL   = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

FILE: src/ordered_key_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_key_list_engine_unit - bounded ordered list of keys
// Keeps up to DEPTH keys in arrival order in a single-port-write RAM, with
// live entries always packed into slots 0 .. size-1.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_command, in_key) is taken at a rising edge with start high
//   and busy low. Commands: append, delete first match, delete all matches,
//   search, clear. Each request yields exactly one result, shown for one
//   cycle with out_valid high; the receiver cannot hold it off.
// Results and throughput:
//   Append, clear, unused codes and any request on an empty list: result in
//   the cycle after acceptance, and busy stays low, so one request a cycle.
//   Delete first, delete all and search walk every live entry through the
//   RAM read port, one entry a cycle; the deletes compact survivors through
//   the write port behind the read pointer. Busy is high during the walk
//   and the result shows in the same cycle as busy falls, so no new request
//   is taken until the walk ends.
// Reset:
//   rst_n low empties the list; no clearing pass over the RAM is needed, as
//   slots at or above the size are never read.
// ----------------------------------------------------------------------------
module ordered_key_list_engine_unit #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [okl_pkg::CMD_W-1:0]        in_command,
  input  logic [okl_pkg::IN_KEY_W-1:0]     in_key,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [okl_pkg::POSITION_W-1:0]   out_position,
  output logic [okl_pkg::COUNT_W-1:0]      out_removed,
  output logic [okl_pkg::COUNT_W-1:0]      out_size,
  output logic                             out_overflow
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // Controller state
  okl_pkg::state_t state_r, state_nxt;
  okl_pkg::cmd_e_t cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic [CW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 dv_r, dv_nxt;
  logic [AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;

  // Result register
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [okl_pkg::POSITION_W-1:0]  out_position_r, out_position_nxt;
  logic [okl_pkg::COUNT_W-1:0]     out_removed_r, out_removed_nxt;
  logic [okl_pkg::COUNT_W-1:0]     out_size_r, out_size_nxt;
  logic                            out_overflow_r, out_overflow_nxt;

  // RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [KEY_WIDTH-1:0] ram_rdata;

  // Request decode and scan datapath
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_in;
  okl_pkg::cmd_e_t      cmd_in;
  logic                 accept;
  logic                 match;
  logic                 first;
  logic                 drop;
  logic                 last;
  logic [CW-1:0]        rem_fin;
  logic [AW-1:0]        pos_fin;
  logic                 found_fin;
  logic [CW-1:0]        occ_left;

  assign key_ext = {32'b0, in_key};
  assign key_in  = key_ext[KEY_WIDTH-1:0];
  assign cmd_in  = okl_pkg::cmd_e_t'(in_command);
  assign busy    = (state_r == okl_pkg::ST_SCAN);
  assign accept  = start && !busy;

  okl_ram #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (rd_ptr_r[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // Compare the entry coming out of the RAM against the held key
  assign match     = dv_r && (ram_rdata == key_r);
  assign first     = match && !found_r;
  assign drop      = match && ((cmd_r == okl_pkg::CMD_DEL_ALL) ||
                               ((cmd_r == okl_pkg::CMD_DEL_FIRST) && !found_r));
  assign last      = dv_r && (CW'(cmp_idx_r) == (occ_r - ONE_C));
  assign rem_fin   = rem_r + CW'(drop);
  assign found_fin = found_r || first;
  assign pos_fin   = first ? cmp_idx_r : pos_r;
  assign occ_left  = occ_r - rem_fin;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      okl_pkg::ST_IDLE: begin
        if (accept && (occ_r != '0) &&
            ((cmd_in == okl_pkg::CMD_DEL_FIRST) || (cmd_in == okl_pkg::CMD_DEL_ALL) ||
             (cmd_in == okl_pkg::CMD_SEARCH))) begin
          state_nxt = okl_pkg::ST_SCAN;
        end
      end
      okl_pkg::ST_SCAN: begin
        if (last) begin
          state_nxt = okl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = okl_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM accesses and result
  always_comb begin
    cmd_nxt          = cmd_r;
    key_nxt          = key_r;
    occ_nxt          = occ_r;
    rd_ptr_nxt       = rd_ptr_r;
    cmp_idx_nxt      = cmp_idx_r;
    dv_nxt           = 1'b0;
    wr_ptr_nxt       = wr_ptr_r;
    rem_nxt          = rem_r;
    found_nxt        = found_r;
    pos_nxt          = pos_r;
    ram_we           = 1'b0;
    ram_waddr        = wr_ptr_r;
    ram_wdata        = ram_rdata;
    out_valid_nxt    = 1'b0;
    out_found_nxt    = 1'b0;
    out_position_nxt = '0;
    out_removed_nxt  = '0;
    out_size_nxt     = okl_pkg::COUNT_W'(occ_r);
    out_overflow_nxt = 1'b0;

    unique case (state_r)
      okl_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          // Arm the walk; it is only entered for a scan command on a
          // non-empty list, otherwise the result below stands
          cmd_nxt    = cmd_in;
          key_nxt    = key_in;
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          rem_nxt    = '0;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          case (cmd_in) inside
            okl_pkg::CMD_APPEND: begin
              if (occ_r == DEPTH_C) begin
                out_overflow_nxt = 1'b1;
              end else begin
                ram_we       = 1'b1;
                ram_waddr    = occ_r[AW-1:0];
                ram_wdata    = key_in;
                occ_nxt      = occ_r + ONE_C;
                out_size_nxt = okl_pkg::COUNT_W'(occ_r + ONE_C);
              end
            end
            okl_pkg::CMD_DEL_FIRST, okl_pkg::CMD_DEL_ALL, okl_pkg::CMD_SEARCH: begin
              // Hold the result back until the walk ends
              if (occ_r != '0) begin
                out_valid_nxt = 1'b0;
              end
            end
            okl_pkg::CMD_CLEAR: begin
              occ_nxt         = '0;
              out_removed_nxt = okl_pkg::COUNT_W'(occ_r);
              out_size_nxt    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      okl_pkg::ST_SCAN: begin
        // Issue the next read while entries remain
        if (rd_ptr_r < occ_r) begin
          rd_ptr_nxt  = rd_ptr_r + ONE_C;
          cmp_idx_nxt = rd_ptr_r[AW-1:0];
          dv_nxt      = 1'b1;
        end
        // Write survivors back behind the read pointer
        if (dv_r && !drop && (cmd_r != okl_pkg::CMD_SEARCH)) begin
          ram_we     = 1'b1;
          ram_waddr  = wr_ptr_r;
          ram_wdata  = ram_rdata;
          wr_ptr_nxt = wr_ptr_r + AW'(1);
        end
        rem_nxt   = rem_fin;
        found_nxt = found_fin;
        pos_nxt   = pos_fin;
        if (last) begin
          dv_nxt          = 1'b0;
          occ_nxt         = occ_left;
          out_valid_nxt   = 1'b1;
          out_removed_nxt = okl_pkg::COUNT_W'(rem_fin);
          out_size_nxt    = okl_pkg::COUNT_W'(occ_left);
          if ((cmd_r != okl_pkg::CMD_DEL_ALL) && found_fin) begin
            out_found_nxt    = 1'b1;
            out_position_nxt = okl_pkg::POSITION_W'(pos_fin);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= okl_pkg::ST_IDLE;
      occ_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    key_r          <= key_nxt;
    rd_ptr_r       <= rd_ptr_nxt;
    cmp_idx_r      <= cmp_idx_nxt;
    wr_ptr_r       <= wr_ptr_nxt;
    rem_r          <= rem_nxt;
    found_r        <= found_nxt;
    pos_r          <= pos_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
    out_removed_r  <= out_removed_nxt;
    out_size_r     <= out_size_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_removed  = out_removed_r;
  assign out_size     = out_size_r;
  assign out_overflow = out_overflow_r;

  // Occupancy never exceeds the store
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C)
    else $error("occupancy above DEPTH");

  // A walk only runs over a non-empty list
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == okl_pkg::ST_SCAN) |-> (occ_r != '0))
    else $error("walk on an empty list");

  // Compaction writes never overtake the entry being compared
  a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == okl_pkg::ST_SCAN) && dv_r) |-> (wr_ptr_r <= cmp_idx_r))
    else $error("write pointer ahead of compare index");

  // A found match removes at most one entry
  a_found_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_removed_r <= okl_pkg::COUNT_W'(1)))
    else $error("found result with more than one removal");

endmodule

FILE: src/okl_ram.sv
// ----------------------------------------------------------------------------
// okl_ram - entry store of the ordered key list engine
// One write port and one read port, synchronous, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module okl_ram #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KEY_WIDTH-1:0]     wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [KEY_WIDTH-1:0]     rd_data
);

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
